// ===== rtl/core/dnn_split_point_selector_macros.svh =====
// Assertion macros shared by the split point selector checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DNN_SPLIT_POINT_SELECTOR_MACROS_SVH
`define DNN_SPLIT_POINT_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DSPS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DSPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dsps_pkg.sv =====
// Shared types, constants and lookup tables of the split point selector.
// No dependencies; used by every module of the block.
package dsps_pkg;

  localparam int unsigned NUM_SPLITS_DEF = 5;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned ACC_W          = 82;
  localparam int unsigned QUOT_W         = 48;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA  = 2'd1;

  localparam logic [31:0] TIMER_FREQ_RST = 32'd100000000;
  localparam logic [15:0] EMA_ALPHA_RST  = 16'd6554;
  localparam logic [31:0] BW_AVG_RST     = 32'd2560000;
  localparam logic [31:0] RTT_MIN        = 32'd65;
  localparam logic [17:0] MS_SCALE       = 18'd256000;
  localparam logic [47:0] SAT48          = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] CEIL_Q16       = 48'h0098_967F_0000;
  localparam logic [ACC_W-1:0] ROUND_Q16 = ACC_W'(32768);

  typedef enum logic [1:0] {
    OP_EDGE   = 2'd0,
    OP_BW     = 2'd1,
    OP_SELECT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  block;
    logic [47:0] cycles;
    logic [31:0] bytes;
    logic [31:0] rtt_ms_q16;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  split_sel;
    logic        found;
    logic [47:0] best_time_ms_q16;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [2:0]  block;
    logic [47:0] cycles;
    logic [31:0] bytes;
    logic [31:0] rtt;
  } cmd_t;

  // Activation bytes shipped to the server after split k.
  function automatic logic [19:0] act_bytes_f(input logic [31:0] k);
    logic [19:0] r;
    case (k)
      32'd0:   r = 20'd802816;
      32'd1:   r = 20'd802816;
      32'd2:   r = 20'd401408;
      32'd3:   r = 20'd200704;
      32'd4:   r = 20'd4000;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

  // Server time in whole ms after split k.
  function automatic logic [5:0] server_ms_f(input logic [31:0] k);
    logic [5:0] r;
    case (k)
      32'd0:   r = 6'd45;
      32'd1:   r = 6'd30;
      32'd2:   r = 6'd18;
      32'd3:   r = 6'd8;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/dnn_split_point_selector.sv =====
// Split point selector: a request either records a block's edge cycles, records a
// bandwidth sample, or asks for the best split. The front queues up to two requests
// and drops the ones with no effect (block number out of range, round trip of
// 0.001 ms or less, unused op) in the cycle they arrive. The back runs one request
// at a time: a first block sample is stored directly, a block average update runs
// an 8-step MAC, a bandwidth sample a 48-step serial divide then an 8-step MAC. A
// select runs two divides per split in the shared serial divider (48 quotient
// steps each); a split with no activation bytes or a zero bandwidth skips the
// second divide.
// Depends on dsps_pkg, dsps_front, dsps_back and dsps_div.
module dnn_split_point_selector #(
  parameter int unsigned NUM_SPLITS = dsps_pkg::NUM_SPLITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  dsps_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output dsps_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dsps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dsps_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [31:0]    timer_freq_q;
  logic [15:0]    alpha_q;
  logic           cmd_valid, cmd_pop;
  dsps_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_freq_q <= dsps_pkg::TIMER_FREQ_RST;
      alpha_q      <= dsps_pkg::EMA_ALPHA_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dsps_pkg::CFG_TIMER_FREQ: timer_freq_q <= cfg_data_i;
        dsps_pkg::CFG_EMA_ALPHA:  alpha_q      <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  dsps_front #(.NUM_SPLITS(NUM_SPLITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  dsps_back #(.NUM_SPLITS(NUM_SPLITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .timer_freq_i(timer_freq_q),
    .alpha_i     (alpha_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/dsps_front.sv =====
// Front end: accepts requests, drops those with no effect, queues the rest.
// Depends on dsps_pkg.
module dsps_front #(
  parameter int unsigned NUM_SPLITS = dsps_pkg::NUM_SPLITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dsps_pkg::in_item_t in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i,
  output dsps_pkg::cmd_t     cmd_o
);

  localparam int unsigned PW = $clog2(dsps_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(dsps_pkg::QUEUE_DEPTH + 1);

  dsps_pkg::cmd_t entry_q [dsps_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           keep, push;
  dsps_pkg::op_e  op;
  dsps_pkg::cmd_t cmd_new;

  assign op = dsps_pkg::op_e'(in_data_i.op);

  always_comb begin
    case (op)
      dsps_pkg::OP_EDGE:   keep = 32'(in_data_i.block) < NUM_SPLITS;
      dsps_pkg::OP_BW:     keep = in_data_i.rtt_ms_q16 > dsps_pkg::RTT_MIN;
      dsps_pkg::OP_SELECT: keep = 1'b1;
      default:             keep = 1'b0;
    endcase
  end

  assign cmd_new.op     = op;
  assign cmd_new.block  = in_data_i.block;
  assign cmd_new.cycles = in_data_i.cycles;
  assign cmd_new.bytes  = in_data_i.bytes;
  assign cmd_new.rtt    = in_data_i.rtt_ms_q16;

  assign in_stall_o  = cnt_q == CW'(dsps_pkg::QUEUE_DEPTH);
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = entry_q[rd_ptr_q];
  assign cnt_d       = cnt_q + CW'(push) - CW'(cmd_pop_i && cmd_valid_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (cmd_pop_i && cmd_valid_o) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/core/dsps_div.sv =====
// Serial restoring divider, one quotient bit per cycle, 48-bit saturating.
// Depends on dsps_pkg.
module dsps_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dsps_pkg::ACC_W-1:0] dividend_i,
  input  logic [31:0]                divisor_i,
  output logic                       done_o,
  output logic [dsps_pkg::QUOT_W-1:0] quot_o
);

  localparam int unsigned QW = dsps_pkg::QUOT_W;
  localparam int unsigned HW = dsps_pkg::ACC_W - QW;

  logic          busy_q, done_q;
  logic [5:0]    cnt_q;
  logic [31:0]   rem_q, dsr_q;
  logic [QW-1:0] num_q;
  logic [32:0]   trial;
  logic          fits;

  assign trial  = {rem_q, num_q[QW-1]};
  assign fits   = trial >= {1'b0, dsr_q};
  assign done_o = done_q;
  assign quot_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      num_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dsr_q <= divisor_i;
        // High part not below the divisor: quotient needs more than 48 bits.
        if (dividend_i[dsps_pkg::ACC_W-1:QW] >= HW'(divisor_i)) begin
          num_q  <= dsps_pkg::SAT48;
          done_q <= 1'b1;
        end else begin
          rem_q  <= dividend_i[QW+31:QW];
          num_q  <= dividend_i[QW-1:0];
          busy_q <= 1'b1;
          cnt_q  <= 6'(QW - 1);
        end
      end else if (busy_q) begin
        rem_q <= fits ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
        num_q <= {num_q[QW-2:0], fits};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/dsps_back.sv =====
// Back end: moving average updates and split scoring with a shared MAC and divider.
// Depends on dsps_pkg and dsps_div.
module dsps_back #(
  parameter int unsigned NUM_SPLITS = dsps_pkg::NUM_SPLITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  dsps_pkg::cmd_t      cmd_i,
  input  logic [31:0]         timer_freq_i,
  input  logic [15:0]         alpha_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dsps_pkg::out_item_t out_data_o
);

  localparam int unsigned KW = (NUM_SPLITS > 1) ? $clog2(NUM_SPLITS) : 1;
  localparam int unsigned AW = dsps_pkg::ACC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_BWDIV = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_EDIV  = 3'd4;
  localparam logic [2:0] S_LDIV  = 3'd5;
  localparam logic [2:0] S_SCORE = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [1:0] MAC_EDGE_AVG = 2'd0;
  localparam logic [1:0] MAC_BW_AVG   = 2'd1;
  localparam logic [1:0] MAC_EDGE_MS  = 2'd2;

  logic [2:0]          state_q;
  dsps_pkg::cmd_t      cur_q;
  logic [55:0]         avg_q [NUM_SPLITS];
  logic [31:0]         bw_avg_q;
  logic [KW-1:0]       k_q;
  logic [63:0]         sum_q, sum_d;
  logic [47:0]         best_t_q, edge_t_q, link_q;
  logic [2:0]          best_k_q;
  logic                found_q;
  logic [63:0]         mac_x0_q, mac_x1_q;
  logic [17:0]         mac_c0_q, mac_c1_q;
  logic [AW-1:0]       acc_q, acc_d;
  logic [2:0]          step_q, mac_last_q;
  logic [1:0]          mac_mode_q;
  logic                out_valid_q;
  dsps_pkg::out_item_t out_q;
  logic                div_start_q;
  logic [AW-1:0]       div_dvd_q;
  logic [31:0]         div_dsr_q;
  logic                div_done;
  logic [47:0]         div_quot;

  logic [63:0]   mac_x;
  logic [17:0]   mac_c;
  logic [15:0]   mac_chunk;
  logic [33:0]   mac_prod;
  logic [KW-1:0] cmd_idx, cur_idx;
  logic [31:0]   f_eff, bw_smp;
  logic [17:0]   w_new, w_old;
  logic [19:0]   nb;
  logic [48:0]   s1, s2;
  logic [47:0]   t1, total;

  dsps_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_dvd_q),
    .divisor_i (div_dsr_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // 16 x 18 multiply-accumulate, one operand chunk per cycle
  assign mac_x     = step_q[2] ? mac_x1_q : mac_x0_q;
  assign mac_c     = step_q[2] ? mac_c1_q : mac_c0_q;
  assign mac_chunk = mac_x[16*step_q[1:0] +: 16];
  assign mac_prod  = mac_chunk * mac_c;
  assign acc_d     = acc_q + (AW'(mac_prod) << (16 * step_q[1:0]));

  assign cmd_idx = KW'(cmd_i.block);
  assign cur_idx = KW'(cur_q.block);
  assign f_eff   = (timer_freq_i == '0) ? 32'd1 : timer_freq_i;
  assign w_new   = {2'b00, alpha_i};
  assign w_old   = 18'd65536 - w_new;
  assign sum_d   = sum_q + 64'(avg_q[k_q]);
  assign bw_smp  = (div_quot[47:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
  assign nb      = dsps_pkg::act_bytes_f(32'(k_q));

  assign s1    = {1'b0, edge_t_q} + {1'b0, link_q};
  assign t1    = s1[48] ? dsps_pkg::SAT48 : s1[47:0];
  assign s2    = {1'b0, t1} + 49'({dsps_pkg::server_ms_f(32'(k_q)), 16'h0000});
  assign total = s2[48] ? dsps_pkg::SAT48 : s2[47:0];

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      for (int i = 0; i < NUM_SPLITS; i++) begin
        avg_q[i] <= '0;
      end
      bw_avg_q    <= dsps_pkg::BW_AVG_RST;
      k_q         <= '0;
      sum_q       <= '0;
      best_t_q    <= '0;
      best_k_q    <= '0;
      found_q     <= 1'b0;
      edge_t_q    <= '0;
      link_q      <= '0;
      mac_x0_q    <= '0;
      mac_x1_q    <= '0;
      mac_c0_q    <= '0;
      mac_c1_q    <= '0;
      acc_q       <= '0;
      step_q      <= '0;
      mac_last_q  <= '0;
      mac_mode_q  <= MAC_EDGE_AVG;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      div_start_q <= 1'b0;
      div_dvd_q   <= '0;
      div_dsr_q   <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cur_q <= cmd_i;
            case (cmd_i.op)
              dsps_pkg::OP_EDGE: begin
                if (avg_q[cmd_idx] == '0) begin
                  avg_q[cmd_idx] <= {cmd_i.cycles, 8'h00};
                end else begin
                  mac_x0_q   <= 64'(avg_q[cmd_idx]);
                  mac_x1_q   <= 64'({cmd_i.cycles, 8'h00});
                  mac_c0_q   <= w_old;
                  mac_c1_q   <= w_new;
                  acc_q      <= dsps_pkg::ROUND_Q16;
                  step_q     <= '0;
                  mac_last_q <= 3'd7;
                  mac_mode_q <= MAC_EDGE_AVG;
                  state_q    <= S_MAC;
                end
              end
              dsps_pkg::OP_BW: begin
                div_dvd_q   <= AW'({cmd_i.bytes, 24'h000000}) + AW'(cmd_i.rtt >> 1);
                div_dsr_q   <= cmd_i.rtt;
                div_start_q <= 1'b1;
                state_q     <= S_BWDIV;
              end
              dsps_pkg::OP_SELECT: begin
                k_q      <= '0;
                sum_q    <= '0;
                best_t_q <= dsps_pkg::CEIL_Q16;
                best_k_q <= '0;
                found_q  <= 1'b0;
                state_q  <= S_SUM;
              end
              default: begin
              end
            endcase
          end
        end
        S_MAC: begin
          acc_q  <= acc_d;
          step_q <= step_q + 3'd1;
          if (step_q == mac_last_q) begin
            case (mac_mode_q)
              MAC_EDGE_AVG: begin
                avg_q[cur_idx] <= acc_d[71:16];
                state_q        <= S_IDLE;
              end
              MAC_BW_AVG: begin
                bw_avg_q <= acc_d[47:16];
                state_q  <= S_IDLE;
              end
              default: begin
                // round(sum * 256000 / f)
                div_dvd_q   <= acc_d + AW'(f_eff >> 1);
                div_dsr_q   <= f_eff;
                div_start_q <= 1'b1;
                state_q     <= S_EDIV;
              end
            endcase
          end
        end
        S_BWDIV: begin
          if (div_done) begin
            mac_x0_q   <= 64'(bw_avg_q);
            mac_x1_q   <= 64'(bw_smp);
            mac_c0_q   <= w_old;
            mac_c1_q   <= w_new;
            acc_q      <= dsps_pkg::ROUND_Q16;
            step_q     <= '0;
            mac_last_q <= 3'd7;
            mac_mode_q <= MAC_BW_AVG;
            state_q    <= S_MAC;
          end
        end
        S_SUM: begin
          sum_q      <= sum_d;
          mac_x0_q   <= sum_d;
          mac_c0_q   <= dsps_pkg::MS_SCALE;
          acc_q      <= '0;
          step_q     <= '0;
          mac_last_q <= 3'd3;
          mac_mode_q <= MAC_EDGE_MS;
          state_q    <= S_MAC;
        end
        S_EDIV: begin
          if (div_done) begin
            edge_t_q <= div_quot;
            if (nb == '0) begin
              link_q  <= '0;
              state_q <= S_SCORE;
            end else if (bw_avg_q == '0) begin
              link_q  <= dsps_pkg::SAT48;
              state_q <= S_SCORE;
            end else begin
              div_dvd_q   <= AW'({nb, 24'h000000}) + AW'(bw_avg_q >> 1);
              div_dsr_q   <= bw_avg_q;
              div_start_q <= 1'b1;
              state_q     <= S_LDIV;
            end
          end
        end
        S_LDIV: begin
          if (div_done) begin
            link_q  <= div_quot;
            state_q <= S_SCORE;
          end
        end
        S_SCORE: begin
          if (total < best_t_q) begin
            best_t_q <= total;
            best_k_q <= 3'(k_q);
            found_q  <= 1'b1;
          end
          if (k_q == KW'(NUM_SPLITS - 1)) begin
            state_q <= S_OUT;
          end else begin
            k_q     <= k_q + KW'(1);
            state_q <= S_SUM;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            if (found_q) begin
              out_q.split_sel        <= best_k_q;
              out_q.found            <= 1'b1;
              out_q.best_time_ms_q16 <= best_t_q;
            end else begin
              out_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/dsps_checker.sv =====
// Port-level checks of the split point selector, bound to the top level.
// Depends on dsps_pkg and dnn_split_point_selector_macros.svh.
`include "dnn_split_point_selector_macros.svh"

module dsps_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dsps_pkg::out_item_t out_data_o
);

  `DSPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `DSPS_ASSERT_NOW(a_none_zero, clk_i, rst_ni, out_valid_o && !out_data_o.found, (out_data_o.split_sel == '0) && (out_data_o.best_time_ms_q16 == '0), "no-split result not zero")
  `DSPS_ASSERT_NOW(a_below_ceil, clk_i, rst_ni, out_valid_o && out_data_o.found, out_data_o.best_time_ms_q16 < dsps_pkg::CEIL_Q16, "found split not below ceiling")

endmodule

bind dnn_split_point_selector dsps_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
